FILE: rtl/ils_pkg.sv
// Shared types, field widths and codes for the indexed list store.
package ils_pkg;

  localparam int KIND_W  = 2;
  localparam int POS_W   = 6;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 7;

  localparam logic [KIND_W-1:0] REQ_GET    = 2'd0;
  localparam logic [KIND_W-1:0] REQ_INDEX  = 2'd1;
  localparam logic [KIND_W-1:0] REQ_INSERT = 2'd2;
  localparam logic [KIND_W-1:0] REQ_ERASE  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE     = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]       req_type;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] read_value;
    logic [POS_W-1:0]        found_position;
    logic [CNT_W-1:0]        entry_count;
  } rsp_t;

  typedef struct packed {
    logic              load;
    logic              start_get;
    logic              start_srch;
    logic              start_ins;
    logic              start_era;
    logic              issue;
    logic              shift_wr;
    logic              ins_val;
    logic              era_fin;
    logic              set_res;
    logic [STAT_W-1:0] res_status;
    logic              push;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              full;
    logic              pos_ge_count;
    logic              pos_gt_count;
    logic              count_zero;
    logic              left_zero;
    logic              rd_pend;
    logic              match;
  } sts_t;

endpackage

FILE: rtl/ils_if.sv
// Request and response channel interfaces for the indexed list store.
interface ils_req_if;
  import ils_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ils_rsp_if;
  import ils_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/ils_dpath.sv
// Datapath of the indexed list store: entry memory, count, walk counters and result register.
module ils_dpath #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  ils_pkg::req_t req_data,
  input  ils_pkg::cmd_t cmd,
  output ils_pkg::sts_t sts,
  output ils_pkg::rsp_t rsp_data
);
  import ils_pkg::*;

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW + 1 : POS_W + 1;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];

  logic [KIND_W-1:0]     kind_q;
  logic [POS_W-1:0]      pos_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [CW-1:0]         count;
  logic [AW-1:0]         idx;
  logic [CW-1:0]         left;
  logic [AW-1:0]         rd_addr;
  logic                  rd_pend;
  logic [DATA_WIDTH-1:0] rdata;
  logic [STAT_W-1:0]     res_status;

  logic                  rd_en;
  logic [AW-1:0]         rd_sel;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [CMPW-1:0]       pos_ext;
  logic [CMPW-1:0]       cnt_ext;
  logic [DATA_WIDTH-1:0] in_val;
  logic [63:0]           rd_wide;

  assign pos_ext = CMPW'(pos_q);
  assign cnt_ext = CMPW'(count);
  // Input values are kept in the low DATA_WIDTH bits of their sign extension.
  assign in_val  = DATA_WIDTH'(64'($signed(req_data.item_value)));
  assign rd_wide = 64'($signed(rdata));

  assign sts.kind         = kind_q;
  assign sts.full         = (count == CW'(CAPACITY));
  assign sts.pos_ge_count = (pos_ext >= cnt_ext);
  assign sts.pos_gt_count = (pos_ext > cnt_ext);
  assign sts.count_zero   = (count == '0);
  assign sts.left_zero    = (left == '0);
  assign sts.rd_pend      = rd_pend;
  assign sts.match        = rd_pend && (rdata == val_q);

  always_comb begin
    rd_en   = 1'b0;
    rd_sel  = idx;
    wr_en   = 1'b0;
    wr_addr = rd_addr;
    wr_data = rdata;
    if (cmd.start_get) begin
      rd_en  = 1'b1;
      rd_sel = AW'(pos_q);
    end else if (cmd.issue && (left != '0)) begin
      rd_en = 1'b1;
    end
    if (cmd.shift_wr && rd_pend) begin
      wr_en   = 1'b1;
      wr_addr = (kind_q == REQ_INSERT) ? rd_addr + AW'(1) : rd_addr - AW'(1);
    end else if (cmd.ins_val) begin
      wr_en   = 1'b1;
      wr_addr = AW'(pos_q);
      wr_data = val_q;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_sel];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= req_data.req_type;
      pos_q  <= req_data.position;
      val_q  <= in_val;
    end
    if (rd_en) begin
      rd_addr <= rd_sel;
    end
    if (cmd.start_srch) begin
      idx  <= '0;
      left <= count;
    end else if (cmd.start_ins) begin
      idx  <= AW'(count - CW'(1));
      left <= CW'(cnt_ext - pos_ext);
    end else if (cmd.start_era) begin
      idx  <= AW'(pos_q) + AW'(1);
      left <= CW'(cnt_ext - pos_ext - CMPW'(1));
    end else if (cmd.issue && (left != '0)) begin
      idx  <= (kind_q == REQ_INSERT) ? idx - AW'(1) : idx + AW'(1);
      left <= left - CW'(1);
    end
    if (cmd.set_res) begin
      res_status <= cmd.res_status;
    end
    if (cmd.push) begin
      rsp_data.status         <= res_status;
      rsp_data.read_value     <= ((kind_q == REQ_GET) && (res_status == ST_OK)) ?
                                 rd_wide[VAL_W-1:0] : '0;
      rsp_data.found_position <= ((kind_q == REQ_INDEX) && (res_status == ST_OK)) ?
                                 POS_W'(rd_addr) : '0;
      rsp_data.entry_count    <= CNT_W'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= rd_en;
      if (cmd.ins_val) begin
        count <= count + CW'(1);
      end else if (cmd.era_fin) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: rtl/ils_ctrl.sv
// Controller state machine of the indexed list store.
module ils_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  logic          rsp_ready,
  output logic          rsp_valid,
  input  ils_pkg::sts_t sts,
  output ils_pkg::cmd_t cmd
);
  import ils_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_GETW   = 3'd2;
  localparam logic [2:0] S_SRCH   = 3'd3;
  localparam logic [2:0] S_INS    = 3'd4;
  localparam logic [2:0] S_ERA    = 3'd5;
  localparam logic [2:0] S_RESULT = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       rsp_valid_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    state_next     = state;
    rsp_valid_next = rsp_valid && !rsp_ready;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.set_res = 1'b1;
        state_next  = S_RESULT;
        case (sts.kind)
          REQ_GET: begin
            if (sts.pos_ge_count) begin
              cmd.res_status = ST_RANGE;
            end else begin
              cmd.res_status = ST_OK;
              cmd.start_get  = 1'b1;
              state_next     = S_GETW;
            end
          end
          REQ_INDEX: begin
            if (sts.count_zero) begin
              cmd.res_status = ST_NOT_FOUND;
            end else begin
              cmd.set_res    = 1'b0;
              cmd.start_srch = 1'b1;
              state_next     = S_SRCH;
            end
          end
          REQ_INSERT: begin
            if (sts.full) begin
              cmd.res_status = ST_FULL;
            end else if (sts.pos_gt_count) begin
              cmd.res_status = ST_RANGE;
            end else begin
              cmd.set_res   = 1'b0;
              cmd.start_ins = 1'b1;
              state_next    = S_INS;
            end
          end
          default: begin
            if (sts.pos_ge_count) begin
              cmd.res_status = ST_RANGE;
            end else begin
              cmd.set_res   = 1'b0;
              cmd.start_era = 1'b1;
              state_next    = S_ERA;
            end
          end
        endcase
      end
      S_GETW: begin
        state_next = S_RESULT;
      end
      S_SRCH: begin
        // Stop reading on a hit so that the matching address stays put.
        if (sts.match) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_OK;
          state_next     = S_RESULT;
        end else if (sts.left_zero) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_NOT_FOUND;
          state_next     = S_RESULT;
        end else begin
          cmd.issue = 1'b1;
        end
      end
      S_INS: begin
        cmd.issue    = 1'b1;
        cmd.shift_wr = 1'b1;
        if (sts.left_zero && !sts.rd_pend) begin
          cmd.ins_val    = 1'b1;
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_OK;
          state_next     = S_RESULT;
        end
      end
      S_ERA: begin
        cmd.issue    = 1'b1;
        cmd.shift_wr = 1'b1;
        if (sts.left_zero && !sts.rd_pend) begin
          cmd.era_fin    = 1'b1;
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_OK;
          state_next     = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.push       = 1'b1;
          rsp_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

FILE: rtl/indexed_list_store.sv
// Top level of the indexed list store: a fixed-capacity ordered list of signed words.
//
//   Channel  Dir  Payload                                            Handshake
//   req      in   req_type, position, item_value                     valid/ready
//   rsp      out  status, read_value, found_position, entry_count    valid/ready
//
// One request is taken at a time. Index-of, insert and erase walk through the
// single-write, single-read entry memory one entry per cycle.
// Reset clears the count and the control state; the entries themselves are not cleared,
// and only positions below the count are ever read.
// The result waits in the output register while the next request is accepted and
// processed; a new result is loaded only once the previous one has been taken.
module indexed_list_store #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input logic     clk,
  input logic     rst,
  ils_req_if.sink   req,
  ils_rsp_if.source rsp
);
  import ils_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller sequences each request: it checks the request against the count and
  // position, then, unless that check fails, runs the memory read or walk that the request
  // kind calls for, and finally loads the output register.
  ils_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_ready (rsp.ready),
    .rsp_valid (rsp.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the entries, the count, the walk counters and the result
  // register. Insert copies entries upward from the top of the list, erase copies them
  // downward from just above the removed position, and index-of compares each entry
  // read against the searched value as it comes out of the memory.
  ils_dpath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .req_data (req.data),
    .cmd      (cmd),
    .sts      (sts),
    .rsp_data (rsp.data)
  );

endmodule
